[hdl/bmg_pkg.sv]
package bmg_pkg;

  // register indexes of the configuration port
  typedef enum logic [3:0] {
    CFG_SIGMA = 4'd0,
    CFG_MEAN  = 4'd1
  } cfg_reg_t;

  localparam int PIPE_DEPTH = 75;

  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic [23:0] SIGMA_RESET = 24'd65536;

  // Horner divisors; sine runs one step shorter, so its first step is skipped
  function automatic logic [7:0] hr_div(input logic use_sin, input int step);
    logic [7:0] d;
    d = 8'd1;
    if (use_sin) begin
      case (step)
        1: d = 8'd110;
        2: d = 8'd72;
        3: d = 8'd42;
        4: d = 8'd20;
        5: d = 8'd6;
        default: d = 8'd1;
      endcase
    end else begin
      case (step)
        0: d = 8'd132;
        1: d = 8'd90;
        2: d = 8'd56;
        3: d = 8'd30;
        4: d = 8'd12;
        5: d = 8'd2;
        default: d = 8'd1;
      endcase
    end
    return d;
  endfunction

  // floor(2^30 / divisor)
  function automatic logic [29:0] hr_recip(input logic use_sin, input int step);
    logic [29:0] m;
    m = 30'd0;
    if (use_sin) begin
      case (step)
        1: m = 30'd9761289;
        2: m = 30'd14913080;
        3: m = 30'd25565281;
        4: m = 30'd53687091;
        5: m = 30'd178956970;
        default: m = 30'd0;
      endcase
    end else begin
      case (step)
        0: m = 30'd8134407;
        1: m = 30'd11930464;
        2: m = 30'd19173961;
        3: m = 30'd35791394;
        4: m = 30'd89478485;
        5: m = 30'd536870912;
        default: m = 30'd0;
      endcase
    end
    return m;
  endfunction

endpackage

[hdl/box_muller_gaussian.sv]
// Valid travels with the data through the shift register vld_r; out_tvalid is its last bit.
// Throughput: one sample per clock; a stalled output freezes the whole pipeline.
// Depth is set by the 30 squaring stages of the log2 and the 32 stages of the
// square root; the phase and cosine path runs alongside them.
// Reset (synchronous, rst_n low) clears all valid bits, sigma to 1.0, mean to 0.
module box_muller_gaussian #(
  parameter int UNIFORM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] uniform_radius, [63:32] uniform_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] gauss_sample
  output logic [0:0]  out_tuser,  // [0] clipped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int L  = bmg_pkg::PIPE_DEPTH;
  localparam int XW = (UNIFORM_BITS < 32) ? UNIFORM_BITS : 32;
  localparam int HW = $clog2(UNIFORM_BITS + 1);
  localparam int SW = HW + 32;

  logic adv;
  logic [L-1:0] vld_r;
  logic [23:0] sigma_r;
  logic [31:0] mean_r;

  assign adv       = !vld_r[L-1] || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      sigma_r <= bmg_pkg::SIGMA_RESET;
      mean_r  <= '0;
    end else begin
      if (adv) vld_r <= {vld_r[L-2:0], in_tvalid};
      if (cfg_valid) begin
        if (cfg_index == bmg_pkg::CFG_SIGMA) sigma_r <= cfg_data[23:0];
        else if (cfg_index == bmg_pkg::CFG_MEAN) mean_r <= cfg_data;
      end
    end
  end

  // ---------------- input capture ----------------
  logic [31:0] x_in, p_in;
  assign x_in = (in_tdata[XW-1:0] == '0) ? 32'd1 : 32'(in_tdata[XW-1:0]);

  generate
    if (UNIFORM_BITS >= 32) begin : g_ph_wide
      assign p_in = in_tdata[63:32] >> (UNIFORM_BITS - 32);
    end else begin : g_ph_narrow
      assign p_in = {in_tdata[32 +: UNIFORM_BITS], {(32 - UNIFORM_BITS){1'b0}}};
    end
  endgenerate

  // ---------------- leading-zero normalize, stages 0..5 ----------------
  logic [31:0] nm_r [0:5];
  logic [4:0]  lz_r [0:5];
  logic [31:0] ph_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_r[0] <= x_in;
      lz_r[0] <= '0;
      ph_r    <= p_in;
    end
  end

  genvar gi;
  generate
    for (gi = 1; gi <= 5; gi++) begin : g_norm
      localparam int SH = 16 >> (gi - 1);
      always_ff @(posedge clk) begin
        if (adv) begin
          if (nm_r[gi-1][31 -: SH] == '0) begin
            nm_r[gi] <= nm_r[gi-1] << SH;
            lz_r[gi] <= lz_r[gi-1] + 5'(SH);
          end else begin
            nm_r[gi] <= nm_r[gi-1];
            lz_r[gi] <= lz_r[gi-1];
          end
        end
      end
    end
  endgenerate

  // ---------------- log2 squarings, stages 6..35 ----------------
  logic [31:0] sm_r [0:29];
  logic [29:0] sf_r [0:29];
  logic [4:0]  se_r [0:29];

  generate
    for (gi = 0; gi < 30; gi++) begin : g_sq
      logic [31:0] m_prev;
      logic [29:0] f_prev;
      logic [4:0]  e_prev;
      logic [63:0] sq;
      if (gi == 0) begin : g_first
        assign m_prev = nm_r[5];
        assign f_prev = '0;
        assign e_prev = 5'd31 - lz_r[5];
      end else begin : g_next
        assign m_prev = sm_r[gi-1];
        assign f_prev = sf_r[gi-1];
        assign e_prev = se_r[gi-1];
      end
      assign sq = 64'(m_prev) * 64'(m_prev);
      always_ff @(posedge clk) begin
        if (adv) begin
          se_r[gi] <= e_prev;
          if (sq[63]) begin
            sm_r[gi] <= sq[63:32];
            sf_r[gi] <= {f_prev[28:0], 1'b1};
          end else begin
            sm_r[gi] <= sq[62:31];
            sf_r[gi] <= {f_prev[28:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // ---------------- -2 ln u1, stages 36..37 ----------------
  logic [HW-1:0] hi_r;
  logic [29:0]   lo_r;
  logic [SW-1:0] s_r;
  logic [60:0]   lo_prod;

  assign lo_prod = 61'(lo_r) * 61'(bmg_pkg::TWO_LN2_Q30);

  always_ff @(posedge clk) begin
    if (adv) begin
      // integer and fraction parts of UNIFORM_BITS - log2(x)
      hi_r <= HW'(UNIFORM_BITS) - HW'(se_r[29]) - HW'(sf_r[29] != '0);
      lo_r <= 30'(31'(bmg_pkg::ONE_Q30) - {1'b0, sf_r[29]});
      s_r  <= SW'(hi_r) * SW'(bmg_pkg::TWO_LN2_Q30) + SW'(lo_prod[60:30]);
    end
  end

  // ---------------- square root, stages 38..69 ----------------
  logic [63:0] rem_r [0:31];
  logic [63:0] res_r [0:31];

  generate
    for (gi = 0; gi < 32; gi++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gi);
      logic [63:0] rem_p, res_p, trial;
      if (gi == 0) begin : g_first
        assign rem_p = 64'({s_r, 26'd0});
        assign res_p = '0;
      end else begin : g_next
        assign rem_p = rem_r[gi-1];
        assign res_p = res_r[gi-1];
      end
      assign trial = res_p + BIT;
      always_ff @(posedge clk) begin
        if (adv) begin
          if (rem_p >= trial) begin
            rem_r[gi] <= rem_p - trial;
            res_r[gi] <= (res_p >> 1) + BIT;
          end else begin
            rem_r[gi] <= rem_p;
            res_r[gi] <= res_p >> 1;
          end
        end
      end
    end
  endgenerate

  // ---------------- phase fold and sin/cos, stages 1..22 ----------------
  logic [29:0] pf_r;
  logic [29:0] pang_r [2:21];
  logic [29:0] px2_r  [3:21];
  logic [30:0] pt_r   [3:21];
  logic [29:0] py_r   [4:21];
  logic [29:0] pq_r   [4:21];
  logic        pus_r  [1:21];
  logic        png_r  [1:73];
  logic [30:0] cc_r   [22:71];
  logic [60:0] ang_prod, ang_sq, sin_prod;

  assign ang_prod = 61'(pf_r) * 61'(bmg_pkg::HALF_PI_Q30);
  assign ang_sq   = 61'(pang_r[2]) * 61'(pang_r[2]);
  assign sin_prod = 61'(pang_r[21]) * 61'(pt_r[21]);

  always_ff @(posedge clk) begin
    if (adv) begin
      // quadrant fold: keep the reduced angle at or below an eighth turn
      if (ph_r[29:0] > 30'h2000_0000) begin
        pf_r     <= 30'(31'(bmg_pkg::ONE_Q30) - {1'b0, ph_r[29:0]});
        pus_r[1] <= !ph_r[30];
      end else begin
        pf_r     <= ph_r[29:0];
        pus_r[1] <= ph_r[30];
      end
      png_r[1]  <= ph_r[31] ^ ph_r[30];
      pang_r[2] <= ang_prod[59:30];
      pus_r[2]  <= pus_r[1];
      pang_r[3] <= pang_r[2];
      px2_r[3]  <= ang_sq[59:30];
      pt_r[3]   <= bmg_pkg::ONE_Q30;
      pus_r[3]  <= pus_r[2];
      cc_r[22]  <= pus_r[21] ? sin_prod[60:30] : pt_r[21];
    end
  end

  generate
    for (gi = 2; gi <= 73; gi++) begin : g_neg
      always_ff @(posedge clk) begin
        if (adv) png_r[gi] <= png_r[gi-1];
      end
    end
    for (gi = 23; gi <= 71; gi++) begin : g_cdly
      always_ff @(posedge clk) begin
        if (adv) cc_r[gi] <= cc_r[gi-1];
      end
    end
    for (gi = 4; gi <= 21; gi++) begin : g_horner
      localparam int STEP = (gi - 4) / 3;
      localparam int SUB  = (gi - 4) % 3;
      logic [60:0] mul_y;
      logic [59:0] mul_q;
      logic [37:0] qd;
      logic [30:0] rm;
      logic [29:0] qq;
      logic [7:0]  dv;
      assign dv    = bmg_pkg::hr_div(pus_r[gi-1], STEP);
      assign mul_y = 61'(px2_r[gi-1]) * 61'(pt_r[gi-1]);
      if (gi == 4) begin : g_nopq
        assign mul_q = '0;
        assign qd    = '0;
        assign rm    = '0;
        assign qq    = '0;
      end else begin : g_pq
        assign mul_q = 60'(py_r[gi-1]) * 60'(bmg_pkg::hr_recip(pus_r[gi-1], STEP));
        assign qd    = 38'(pq_r[gi-1]) * 38'(dv);
        assign rm    = {1'b0, py_r[gi-1]} - 31'(qd);
        assign qq    = pq_r[gi-1] + 30'(rm >= 31'(dv));
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          pang_r[gi] <= pang_r[gi-1];
          px2_r[gi]  <= px2_r[gi-1];
          pus_r[gi]  <= pus_r[gi-1];
          if (SUB == 2 && !(pus_r[gi-1] && STEP == 0)) pt_r[gi] <= bmg_pkg::ONE_Q30 - {1'b0, qq};
          else pt_r[gi] <= pt_r[gi-1];
          if (SUB == 0) begin
            py_r[gi] <= mul_y[59:30];
            pq_r[gi] <= '0;
          end else if (SUB == 1) begin
            py_r[gi] <= py_r[gi-1];
            pq_r[gi] <= mul_q[59:30];
          end else begin
            py_r[gi] <= py_r[gi-1];
            pq_r[gi] <= qq;
          end
        end
      end
    end
  endgenerate

  // ---------------- scale, sign, saturate, stages 70..74 ----------------
  logic [55:0] prod_r;
  logic [58:0] pa_r;
  logic [27:0] pb_lo_r;
  logic [30:0] pb_r;
  logic [58:0] pa2_r;
  logic [29:0] mag_r;
  logic [31:0] gs_r;
  logic        clip_r;
  logic [58:0] mul_a, mul_b;
  logic [59:0] mag_sum;
  logic signed [33:0] v_s;

  assign mul_a   = 59'(prod_r[55:28]) * 59'(cc_r[70]);
  assign mul_b   = 59'(pb_lo_r) * 59'(cc_r[71]);
  assign mag_sum = 60'(pa2_r) + 60'(pb_r);
  assign v_s     = png_r[73] ? 34'(signed'(mean_r)) - signed'(34'(mag_r))
                             : 34'(signed'(mean_r)) + signed'(34'(mag_r));

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= 56'(sigma_r) * 56'(res_r[31][31:0]);
      pa_r    <= mul_a;
      pb_lo_r <= prod_r[27:0];
      pa2_r   <= pa_r;
      pb_r    <= mul_b[58:28];
      mag_r   <= mag_sum[59:30];
      if (v_s > 34'sh0_7FFF_FFFF) begin
        gs_r   <= 32'h7FFF_FFFF;
        clip_r <= 1'b1;
      end else if (v_s < -34'sh0_8000_0000) begin
        gs_r   <= 32'h8000_0000;
        clip_r <= 1'b1;
      end else begin
        gs_r   <= v_s[31:0];
        clip_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = vld_r[L-1];
  assign out_tdata    = gs_r;
  assign out_tuser[0] = clip_r;

endmodule

[hdl/bmg_checker.sv]
module bmg_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transaction changed while stalled");

  // saturation flag only with a rail value
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'h7FFF_FFFF || out_tdata == 32'h8000_0000)
    else $error("clipped set on a non-saturated sample");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // input side only stalls when the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready || !out_tvalid |-> in_tready)
    else $error("input stalled while the output drains");

endmodule

bind box_muller_gaussian bmg_props u_bmg_props (.*);
